@@ sv/generational_handle_table_top_macros.svh @@
// assertion macros shared by the handle table checker
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GHTAB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("handle table check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define GHTAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("handle table check failed");

`endif

@@ sv/ghtab_pkg.sv @@
// shared types, field layout constants and codes of the handle table
package ghtab_pkg;

  // handle field layout
  localparam int SLOT_FIELD_W = 22;
  localparam int GEN_FIELD_W  = 26;
  localparam int CORE_SHIFT   = 48;
  localparam int CORE_BITS    = 16;

  localparam int HANDLE_W  = 64;
  localparam int BIND_W    = 32;
  localparam int PAYLOAD_W = 32;

  // parameter defaults
  localparam int SLOTS_DEF         = 64;
  localparam int GEN_WIDTH_DEF     = 26;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_TAKE    = 2'd0,
    OP_BIND    = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch word, issue table reads
    logic commit;   // write back table, load result register
  } ghtab_cmd_t;

endpackage

@@ sv/ghtab_ctrl.sv @@
// controller state machine of the handle table
module ghtab_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_stall,
  output logic                  in_stall,
  output logic                  out_valid,
  output ghtab_pkg::ghtab_cmd_t cmd
);
  import ghtab_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = (state != S_IDLE);
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.commit  = (state == S_EXEC) && (!out_valid || !out_stall);
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

endmodule

@@ sv/ghtab_dp.sv @@
// datapath of the handle table: slot memories, free list and result register
module ghtab_dp #(
  parameter int SLOTS         = ghtab_pkg::SLOTS_DEF,
  parameter int GEN_WIDTH     = ghtab_pkg::GEN_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = ghtab_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ghtab_pkg::ghtab_cmd_t            cmd,
  input  logic [1:0]                       operation,
  input  logic [ghtab_pkg::CORE_BITS-1:0]  core,
  input  logic [ghtab_pkg::HANDLE_W-1:0]   handle_id,
  input  logic [ghtab_pkg::BIND_W-1:0]     bind_value,
  output logic [ghtab_pkg::HANDLE_W-1:0]   handle_out,
  output logic [ghtab_pkg::PAYLOAD_W-1:0]  payload_out,
  output logic [1:0]                       status
);
  import ghtab_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = SLOT_FIELD_W + 1;

  // slot memories
  logic [GEN_WIDTH-1:0]     gen_mem  [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] pay_mem  [SLOTS];
  logic                     busy_mem [SLOTS];
  logic [IDX_W-1:0]         link_mem [SLOTS];

  logic [GEN_WIDTH-1:0]     gen_rd;
  logic [PAYLOAD_WIDTH-1:0] pay_rd;
  logic                     busy_rd;
  logic [IDX_W-1:0]         link_rd;

  // captured word
  op_t                  op_q;
  logic [CORE_BITS-1:0] core_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [BIND_W-1:0]    bind_q;

  // free list: never-issued slots first, then the linked released slots
  logic [CNT_W-1:0] fresh, fresh_next;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             list_empty, list_empty_next;

  logic [IDX_W-1:0] rd_addr;

  logic [SLOT_FIELD_W-1:0] slot_field;
  logic [GEN_FIELD_W-1:0]  gen_field;
  logic [IDX_W-1:0]        hslot;
  logic                    issued, live, core_ok, fresh_avail;
  logic [GEN_WIDTH-1:0]    gen_inc;

  logic                     ent_we, pay_we, link_we;
  logic [IDX_W-1:0]         wr_slot;
  logic [GEN_WIDTH-1:0]     gen_wdata;
  logic                     busy_wdata;
  logic [PAYLOAD_WIDTH-1:0] pay_wdata;

  logic [HANDLE_W-1:0]  res_handle;
  logic [PAYLOAD_W-1:0] res_payload;
  status_t              res_status;

  assign rd_addr = (op_t'(operation) == OP_TAKE) ? head : handle_id[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op_t'(operation);
      core_q   <= core;
      handle_q <= handle_id;
      bind_q   <= bind_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) gen_rd <= gen_mem[rd_addr];
    if (cmd.commit && ent_we) gen_mem[wr_slot] <= gen_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) busy_rd <= busy_mem[rd_addr];
    if (cmd.commit && ent_we) busy_mem[wr_slot] <= busy_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) pay_rd <= pay_mem[rd_addr];
    if (cmd.commit && pay_we) pay_mem[wr_slot] <= pay_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) link_rd <= link_mem[rd_addr];
    if (cmd.commit && link_we) link_mem[tail] <= wr_slot;
  end

  // handle decode and liveness
  assign slot_field  = handle_q[SLOT_FIELD_W-1:0];
  assign gen_field   = handle_q[SLOT_FIELD_W +: GEN_FIELD_W];
  assign hslot       = slot_field[IDX_W-1:0];
  assign issued      = CMP_W'(slot_field) < CMP_W'(fresh);
  assign live        = issued && busy_rd && (gen_field == GEN_FIELD_W'(gen_rd));
  assign core_ok     = (handle_q[CORE_SHIFT +: CORE_BITS] == core_q);
  assign fresh_avail = (fresh != CNT_W'(SLOTS));
  assign gen_inc     = (gen_rd == {GEN_WIDTH{1'b1}}) ? GEN_WIDTH'(1)
                                                     : gen_rd + GEN_WIDTH'(1);

  always_comb begin
    fresh_next      = fresh;
    head_next       = head;
    tail_next       = tail;
    list_empty_next = list_empty;
    ent_we          = 1'b0;
    pay_we          = 1'b0;
    link_we         = 1'b0;
    wr_slot         = hslot;
    gen_wdata       = gen_rd;
    busy_wdata      = 1'b0;
    pay_wdata       = '0;
    res_handle      = '0;
    res_payload     = '0;
    res_status      = ST_MISS;
    unique case (op_q)
      OP_TAKE: begin
        if (fresh_avail || !list_empty) begin
          if (fresh_avail) begin
            wr_slot    = fresh[IDX_W-1:0];
            gen_wdata  = GEN_WIDTH'(1);
            fresh_next = fresh + CNT_W'(1);
          end else begin
            wr_slot   = head;
            gen_wdata = gen_rd;
            if (head == tail) begin
              list_empty_next = 1'b1;
            end else begin
              head_next = link_rd;
            end
          end
          ent_we     = 1'b1;
          busy_wdata = 1'b1;
          pay_we     = 1'b1;
          res_handle = {core_q, GEN_FIELD_W'(gen_wdata), SLOT_FIELD_W'(wr_slot)};
          res_status = ST_OK;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_BIND: begin
        if (live) begin
          pay_we     = 1'b1;
          pay_wdata  = PAYLOAD_WIDTH'(bind_q);
          res_status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (core_ok && live && (pay_rd != '0)) begin
          res_payload = PAYLOAD_W'(pay_rd);
          res_status  = ST_OK;
        end
      end
      OP_RELEASE: begin
        if (live) begin
          ent_we    = 1'b1;
          pay_we    = 1'b1;
          gen_wdata = gen_inc;
          if (list_empty) begin
            head_next       = hslot;
            list_empty_next = 1'b0;
          end else begin
            link_we = 1'b1;
          end
          tail_next  = hslot;
          res_status = ST_OK;
        end
      end
      default: res_status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh      <= '0;
      head       <= '0;
      tail       <= '0;
      list_empty <= 1'b1;
    end else if (cmd.commit) begin
      fresh      <= fresh_next;
      head       <= head_next;
      tail       <= tail_next;
      list_empty <= list_empty_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      handle_out  <= res_handle;
      payload_out <= res_payload;
      status      <= res_status;
    end
  end

endmodule

@@ sv/generational_handle_table_top.sv @@
// top level of the generational handle table
//
// usage
// - input channel: in_valid / in_stall carry one request word (operation, core,
//   handle_id, bind_value); a word is taken when in_valid is high and in_stall low
// - output channel: out_valid / out_stall carry one result word per request
//   (handle_out, payload_out, status), in request order
// - operations: take issues a handle from the free list (status 2 when full),
//   bind stores a payload in a live slot, lookup checks owner core, range,
//   busy mark and generation, release bumps the generation and frees the slot
// - sequence: at acceptance the word is captured and the slot memories read
//   (registered read); in S_EXEC the table is written back, the result register
//   loaded, and in_stall stays high so no new word is taken until then
// - a new word is taken while the previous result still waits in the output
//   register; when the receiver stalls with a result pending, the block keeps
//   the second word and its table reads unfinished and raises in_stall until
//   the output register drains, then finishes it in that cycle
// - reset: synchronous on rst; the free list starts as all slots in index
//   order, tracked by an issue counter so no clearing pass of the memories
//   is needed; the block can take a word as soon as reset is released
module generational_handle_table_top #(
  parameter int SLOTS         = ghtab_pkg::SLOTS_DEF,
  parameter int GEN_WIDTH     = ghtab_pkg::GEN_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = ghtab_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       operation,
  input  logic [ghtab_pkg::CORE_BITS-1:0]  core,
  input  logic [ghtab_pkg::HANDLE_W-1:0]   handle_id,
  input  logic [ghtab_pkg::BIND_W-1:0]     bind_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ghtab_pkg::HANDLE_W-1:0]   handle_out,
  output logic [ghtab_pkg::PAYLOAD_W-1:0]  payload_out,
  output logic [1:0]                       status
);
  import ghtab_pkg::*;

  // commands from the sequencer to the datapath
  ghtab_cmd_t cmd;

  // two-state sequencer: capture word and read, then write back and emit
  ghtab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // slot memories, free list pointers and result register
  ghtab_dp #(
    .SLOTS         (SLOTS),
    .GEN_WIDTH     (GEN_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .core        (core),
    .handle_id   (handle_id),
    .bind_value  (bind_value),
    .handle_out  (handle_out),
    .payload_out (payload_out),
    .status      (status)
  );

endmodule

@@ sv/ghtab_chk.sv @@
// port-level checker of the handle table and its bind to the top level
`include "generational_handle_table_top_macros.svh"

module ghtab_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [1:0]                      operation,
  input logic [ghtab_pkg::CORE_BITS-1:0] core,
  input logic [ghtab_pkg::HANDLE_W-1:0]  handle_id,
  input logic [ghtab_pkg::BIND_W-1:0]    bind_value,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ghtab_pkg::HANDLE_W-1:0]  handle_out,
  input logic [ghtab_pkg::PAYLOAD_W-1:0] payload_out,
  input logic [1:0]                      status
);
  import ghtab_pkg::*;

  // a stalled result word holds
  `GHTAB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(handle_out) && $stable(payload_out) && $stable(status))

  // the block works on one word at a time
  `GHTAB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a failed request returns zero handle and payload
  `GHTAB_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK),
    (handle_out == '0) && (payload_out == '0))

  // only a lookup returns a payload, only a take returns a handle
  `GHTAB_ASSERT_NOW(a_one_kind, out_valid && (payload_out != '0),
    (handle_out == '0) && (status == ST_OK))

endmodule

bind generational_handle_table_top ghtab_chk u_ghtab_chk (.*);

@@ bench/tb_generational_handle_table_top.sv @@
// self-checking bench for the generational handle table: directed plan, then random traffic
`timescale 1ns / 100ps

module tb_generational_handle_table_top;
  import ghtab_pkg::*;

  localparam int SLOT_COUNT  = SLOTS_DEF;
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int PLAN_LEN    = 22;
  localparam int RANDOM_WORDS = 1230;
  localparam int BATCH       = 120;   // words per traffic phase (fill, mixed, drain)
  localparam int HOLD_AT     = 300;   // accepted words before the long receiver hold
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_FROM  = 600;   // window of accepted words with no idling at all
  localparam int QUIET_TO    = 800;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RETIRED_KEEP = 32;

  // handles that are known right after reset
  localparam logic [63:0] H_SLOT0      = 64'hFFFF_0000_0040_0000;  // core ffff, gen 1, slot 0
  localparam logic [63:0] H_SLOT0_GEN2 = 64'hFFFF_0000_0080_0000;  // same slot, gen 2
  localparam logic [63:0] H_OUT_RANGE  = 64'h0000_0000_007F_FFFF;  // gen 1, slot 3fffff
  localparam logic [63:0] H_SLOT1      = 64'h0000_0000_0040_0001;  // core 0, gen 1, slot 1
  localparam logic [63:0] H_SLOT2      = 64'h1234_0000_0040_0002;  // core 1234, gen 1, slot 2

  typedef struct packed {
    logic [63:0] handle;
    logic [31:0] payload;
    status_t     st;
  } word_result_t;

  typedef struct packed {
    op_t          op;
    logic [15:0]  core;
    logic [63:0]  handle;
    logic [31:0]  value;
    logic         typed;      // expectation written below instead of predicted
    word_result_t want;
  } plan_row_t;

  // opening plan: extremes, every operation and each miss reason
  plan_row_t opening_plan [PLAN_LEN] = '{
    '{OP_TAKE,    16'hFFFF, 64'h0,        32'h0,         1'b1, '{H_SLOT0, 32'h0, ST_OK}},
    // live slot but nothing bound yet
    '{OP_LOOKUP,  16'hFFFF, H_SLOT0,      32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    // bind does not look at the core field
    '{OP_BIND,    16'h0000, H_SLOT0,      32'hFFFF_FFFF, 1'b1, '{64'h0, 32'h0, ST_OK}},
    '{OP_LOOKUP,  16'hFFFF, H_SLOT0,      32'h0,         1'b1, '{64'h0, 32'hFFFF_FFFF, ST_OK}},
    // foreign core
    '{OP_LOOKUP,  16'h0000, H_SLOT0,      32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    // wrong generation
    '{OP_LOOKUP,  16'hFFFF, H_SLOT0_GEN2, 32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    // slot index out of range
    '{OP_BIND,    16'h0000, H_OUT_RANGE,  32'h1,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    // release of a slot that is still free
    '{OP_RELEASE, 16'h0000, H_SLOT1,      32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_TAKE,    16'h0000, 64'h0,        32'h0,         1'b1, '{H_SLOT1, 32'h0, ST_OK}},
    '{OP_BIND,    16'h0000, H_SLOT1,      32'h0,         1'b0, '{64'h0, 32'h0, ST_OK}},
    // a zero payload counts as nothing bound
    '{OP_LOOKUP,  16'h0000, H_SLOT1,      32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_BIND,    16'h0000, H_SLOT1,      32'hA5A5_5A5A, 1'b0, '{64'h0, 32'h0, ST_OK}},
    '{OP_LOOKUP,  16'h0000, H_SLOT1,      32'h0,         1'b1, '{64'h0, 32'hA5A5_5A5A, ST_OK}},
    // release ignores the core field too
    '{OP_RELEASE, 16'h0000, H_SLOT0,      32'h0,         1'b1, '{64'h0, 32'h0, ST_OK}},
    // stale handle after release
    '{OP_LOOKUP,  16'hFFFF, H_SLOT0,      32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_RELEASE, 16'hFFFF, H_SLOT0,      32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_BIND,    16'hFFFF, H_SLOT0,      32'h5,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_TAKE,    16'h1234, 64'h0,        32'h0,         1'b1, '{H_SLOT2, 32'h0, ST_OK}},
    '{OP_RELEASE, 16'hFFFF, '1,           32'hFFFF_FFFF, 1'b1, '{64'h0, 32'h0, ST_MISS}},
    // generation zero is never issued
    '{OP_LOOKUP,  16'h0000, 64'h0,        32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_RELEASE, 16'h0000, 64'h0,        32'h0,         1'b1, '{64'h0, 32'h0, ST_MISS}},
    '{OP_TAKE,    16'h8001, 64'h0,        32'h0,         1'b0, '{64'h0, 32'h0, ST_OK}}
  };

  // dut ports; the inputs are all known from time zero
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  operation  = OP_TAKE;
  logic [15:0] core       = '0;
  logic [63:0] handle_id  = '0;
  logic [31:0] bind_value = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [63:0] handle_out;
  logic [31:0] payload_out;
  logic [1:0]  status;

  // shadow copy of the slot table
  logic [GEN_WIDTH_DEF-1:0] slot_gen     [SLOT_COUNT];
  logic [31:0]              slot_payload [SLOT_COUNT];
  logic                     slot_busy    [SLOT_COUNT];
  logic [IDX_W-1:0]         free_link    [SLOT_COUNT];
  logic [IDX_W-1:0]         free_first;
  logic [IDX_W-1:0]         free_last;
  logic                     list_empty;

  word_result_t awaited_results [$];
  logic [63:0]  issued_handles  [$];   // handles believed live
  logic [63:0]  retired_handles [$];   // recently released, now stale

  int mismatches     = 0;
  int accepted_words = 0;
  int checked_words  = 0;
  int cycles         = 0;
  int op_tally [4]   = '{0, 0, 0, 0};
  int status_tally [3] = '{0, 0, 0};
  logic quiet_window;

  assign quiet_window = (accepted_words >= QUIET_FROM) && (accepted_words < QUIET_TO);

  generational_handle_table_top #(
    .SLOTS         (SLOT_COUNT),
    .GEN_WIDTH     (GEN_WIDTH_DEF),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH_DEF)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .core        (core),
    .handle_id   (handle_id),
    .bind_value  (bind_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .handle_out  (handle_out),
    .payload_out (payload_out),
    .status      (status)
  );

  always #1 clk = ~clk;

  // free list in index order, generations at one, nothing bound
  task automatic clear_slot_table();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_gen[i]     = GEN_WIDTH_DEF'(1);
      slot_payload[i] = '0;
      slot_busy[i]    = 1'b0;
      free_link[i]    = IDX_W'((i + 1) % SLOT_COUNT);
    end
    free_first = '0;
    free_last  = IDX_W'(SLOT_COUNT - 1);
    list_empty = 1'b0;
  endtask

  // slot named by a live handle, or -1: range, busy mark, full generation field
  function automatic int live_slot_of(logic [63:0] h);
    if (h[SLOT_FIELD_W-1:0] >= SLOT_COUNT) return -1;
    if (!slot_busy[h[IDX_W-1:0]]) return -1;
    if (slot_gen[h[IDX_W-1:0]] != h[CORE_SHIFT-1:SLOT_FIELD_W]) return -1;
    return int'(h[IDX_W-1:0]);
  endfunction

  // applies one word to the shadow table and returns the result it causes
  function automatic word_result_t apply_handle_op(op_t op, logic [15:0] c,
                                                   logic [63:0] h, logic [31:0] v);
    word_result_t res;
    int s;
    res = '{handle: '0, payload: '0, st: ST_MISS};
    case (op)
      OP_TAKE: begin
        if (list_empty) begin
          res.st = ST_FULL;
        end else begin
          s = int'(free_first);
          if (free_first == free_last) list_empty = 1'b1;
          else free_first = free_link[s];
          slot_busy[s]    = 1'b1;
          slot_payload[s] = '0;
          res.handle = {c, slot_gen[s], SLOT_FIELD_W'(s)};
          res.st     = ST_OK;
        end
      end
      OP_BIND: begin
        s = live_slot_of(h);
        if (s >= 0) begin
          slot_payload[s] = v;
          res.st = ST_OK;
        end
      end
      OP_LOOKUP: begin
        // owner core is checked before the table
        if (h[63:CORE_SHIFT] == c) begin
          s = live_slot_of(h);
          if (s >= 0 && slot_payload[s] != '0) begin
            res.payload = slot_payload[s];
            res.st      = ST_OK;
          end
        end
      end
      default: begin
        s = live_slot_of(h);
        if (s >= 0) begin
          slot_payload[s] = '0;
          // generation skips zero when it wraps
          slot_gen[s]  = (slot_gen[s] == '1) ? GEN_WIDTH_DEF'(1) : slot_gen[s] + 1'b1;
          slot_busy[s] = 1'b0;
          if (list_empty) begin
            free_first = IDX_W'(s);
            list_empty = 1'b0;
          end else begin
            free_link[free_last] = IDX_W'(s);
          end
          free_last = IDX_W'(s);
          res.st = ST_OK;
        end
      end
    endcase
    return res;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // offers one word, waits for the handshake, then predicts its result
  task automatic send_word(op_t op, logic [15:0] c, logic [63:0] h, logic [31:0] v,
                           logic typed, word_result_t typed_want);
    word_result_t res;
    int i;
    // random idle gaps between words, none in the quiet window
    while (!quiet_window && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    core       <= c;
    handle_id  <= h;
    bind_value <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    res = apply_handle_op(op, c, h, v);
    awaited_results.push_back(typed ? typed_want : res);
    accepted_words++;
    op_tally[op]++;
    status_tally[res.st]++;
    // keep track of which handles are live and which went stale
    if (op == OP_TAKE && res.st == ST_OK) issued_handles.push_back(res.handle);
    if (op == OP_RELEASE && res.st == ST_OK) begin
      for (i = issued_handles.size() - 1; i >= 0; i--)
        if (issued_handles[i][CORE_SHIFT-1:0] == h[CORE_SHIFT-1:0]) issued_handles.delete(i);
      retired_handles.push_back(h);
      if (retired_handles.size() > RETIRED_KEEP) void'(retired_handles.pop_front());
    end
  endtask

  // mostly live handles, then stale ones, one-bit corruptions and raw noise
  function automatic logic [63:0] pick_handle();
    logic [63:0] h;
    int r;
    int b;
    r = $urandom_range(99);
    if (r < 75 && issued_handles.size() != 0) begin
      h = issued_handles[$urandom_range(issued_handles.size() - 1)];
    end else if (r < 85 && retired_handles.size() != 0) begin
      h = retired_handles[$urandom_range(retired_handles.size() - 1)];
    end else if (r < 93 && issued_handles.size() != 0) begin
      h = issued_handles[$urandom_range(issued_handles.size() - 1)];
      b = $urandom_range(63);
      h[b] = ~h[b];
    end else begin
      h = {$urandom, $urandom};
    end
    return h;
  endfunction

  // receiver side: random stalls, one long hold, a quiet stretch
  initial begin : receiver_side
    int hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted_words >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // sender keeps offering words meanwhile, so the block backs up
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet_window && ($urandom_range(99) < 6);
      end
      @(posedge clk);
    end
  end

  // compares each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    word_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("result word %0d arrived with nothing expected", checked_words));
      end else begin
        want = awaited_results.pop_front();
        if (handle_out !== want.handle)
          flag_error($sformatf("word %0d handle_out %h, expected %h",
                               checked_words, handle_out, want.handle));
        if (payload_out !== want.payload)
          flag_error($sformatf("word %0d payload_out %h, expected %h",
                               checked_words, payload_out, want.payload));
        if (status !== want.st)
          flag_error($sformatf("word %0d status %0d, expected %0d",
                               checked_words, status, want.st));
      end
      checked_words++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, awaited_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int r;
    int phase;
    op_t op;
    logic [15:0] c;
    logic [63:0] h;
    logic [31:0] v;
    clear_slot_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed plan
    for (n = 0; n < PLAN_LEN; n++)
      send_word(opening_plan[n].op, opening_plan[n].core, opening_plan[n].handle,
                opening_plan[n].value, opening_plan[n].typed, opening_plan[n].want);

    // random traffic in phases: fill the table with mostly takes,
    // mixed use, then drain it back through releases
    for (n = 0; n < RANDOM_WORDS; n++) begin
      phase = (n / BATCH) % 3;
      r = $urandom_range(99);
      case (phase)
        0:       op = (r < 70) ? OP_TAKE : (r < 80) ? OP_BIND : (r < 92) ? OP_LOOKUP : OP_RELEASE;
        1:       op = op_t'(r % 4);
        default: op = (r < 5) ? OP_TAKE : (r < 20) ? OP_BIND : (r < 40) ? OP_LOOKUP : OP_RELEASE;
      endcase
      h = pick_handle();
      c = 16'($urandom_range(16'hFFFF));
      // lookups mostly come from the owner core
      if (op == OP_LOOKUP && $urandom_range(99) < 80) c = h[63:CORE_SHIFT];
      r = $urandom_range(99);
      v = (r < 10) ? 32'h0 : (r < 15) ? 32'hFFFF_FFFF : $urandom;
      send_word(op, c, h, v, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d take, %0d bind, %0d lookup, %0d release",
             accepted_words, op_tally[OP_TAKE], op_tally[OP_BIND],
             op_tally[OP_LOOKUP], op_tally[OP_RELEASE]);
    $display("outcomes: %0d ok, %0d miss or stale, %0d table full; %0d results checked",
             status_tally[ST_OK], status_tally[ST_MISS], status_tally[ST_FULL], checked_words);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ghtab_pkg.sv
sv/ghtab_ctrl.sv
sv/ghtab_dp.sv
sv/generational_handle_table_top.sv
sv/ghtab_chk.sv
bench/tb_generational_handle_table_top.sv
